>>> rtl/tsl_pkg.sv
// Shared types, constants and a helper function for the timestamp range log store.
// No dependencies; compiled first.
package tsl_pkg;

   // Field widths of the channels
   localparam int STAMP_W = 33;
   localparam int ID_W    = 16;
   localparam int GRAN_W  = 3;

   // Defaults for the top-level parameters
   localparam int DEFAULT_DEPTH   = 64;
   localparam int DEFAULT_ID_BITS = 16;

   // Command codes
   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

   // Stamp field layout, year first: yr7 mo4 dy5 hr5 mi6 se6
   localparam int NUM_FLD = 6;
   localparam int unsigned FLD_SHIFT [NUM_FLD] = '{26, 22, 17, 12, 6, 0};
   localparam int unsigned FLD_MASK  [NUM_FLD] = '{'h7F, 'hF, 'h1F, 'h1F, 'h3F, 'h3F};
   localparam int unsigned FLD_LO    [NUM_FLD] = '{0, 1, 1, 0, 0, 0};
   localparam int unsigned FLD_HI    [NUM_FLD] = '{0, 12, 31, 23, 59, 59};

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_FLUSH
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept_put;  // store the item or flag overflow
      logic accept_get;  // latch widened bounds, restart the scan
      logic rd_en;       // read the entry at the scan index
      logic step;        // consume the compare result, advance the index
      logic flush;       // emit the final (or empty) result
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_get;      // the offered item is a retrieve
      logic count_zero;  // store holds no entry
      logic match;       // entry just read lies in range
      logic pend_valid;  // a match is held back awaiting its last flag
      logic out_free;    // output register can take an item this cycle
      logic scan_last;   // scan index is on the final stored entry
   } sts_type;

   // Replace every field finer than the granularity by its low or high bound
   function automatic logic [STAMP_W-1:0] widen_stamp(input logic [STAMP_W-1:0] stamp,
                                                      input logic [GRAN_W-1:0]  gran,
                                                      input logic               hi_side);
      logic [STAMP_W-1:0] res;
      logic [STAMP_W-1:0] msk;
      logic [STAMP_W-1:0] val;
      res = stamp;
      for (int f = 1; f < NUM_FLD; f++) begin
         if (GRAN_W'(f) > gran) begin
            msk = STAMP_W'(FLD_MASK[f]) << FLD_SHIFT[f];
            val = (hi_side ? STAMP_W'(FLD_HI[f]) : STAMP_W'(FLD_LO[f])) << FLD_SHIFT[f];
            res = (res & ~msk) | val;
         end
      end
      return res;
   endfunction

endpackage

>>> rtl/tsl_req_if.sv
// Request channel interface: valid/ready handshake with the command payload.
// Depends on tsl_pkg.
interface tsl_req_if;
   import tsl_pkg::*;

   logic               valid;
   logic               ready;
   logic               cmd;
   logic [ID_W-1:0]    log_id;
   logic [STAMP_W-1:0] first_stamp;
   logic [STAMP_W-1:0] end_stamp;
   logic [GRAN_W-1:0]  granularity;

   modport source (output valid, cmd, log_id, first_stamp, end_stamp, granularity,
                   input  ready);
   modport sink   (input  valid, cmd, log_id, first_stamp, end_stamp, granularity,
                   output ready);
endinterface

>>> rtl/tsl_rsp_if.sv
// Response channel interface: valid/ready handshake with one result item.
// Depends on tsl_pkg.
interface tsl_rsp_if;
   import tsl_pkg::*;

   logic            valid;
   logic            ready;
   logic [ID_W-1:0] match_id;
   logic            empty_res;
   logic            last;
   logic            overflowed;

   modport source (output valid, match_id, empty_res, last, overflowed, input ready);
   modport sink   (input  valid, match_id, empty_res, last, overflowed, output ready);
endinterface

>>> rtl/tsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/tsl_ctrl.sv
// Sequencer for puts and range scans; drives commands into the datapath.
// Depends on tsl_pkg.
module tsl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tsl_pkg::sts_type sts,
   output tsl_pkg::cmd_type cmd
);
   import tsl_pkg::*;

   state_type state_ff, state_in;
   logic      stall;

   // a new match cannot displace the held one while the output is full
   assign stall = sts.match && sts.pend_valid && !sts.out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.is_get) begin
               state_in = sts.count_zero ? ST_FLUSH : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (!stall) begin
               state_in = sts.scan_last ? ST_FLUSH : ST_READ;
            end
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.accept_put = req_valid && !sts.is_get;
            cmd.accept_get = req_valid && sts.is_get;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
         end
         ST_COMPARE: begin
            cmd.step = !stall;
         end
         ST_FLUSH: begin
            cmd.flush = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

>>> rtl/tsl_datapath.sv
// Entry store, range bounds, scan index, held match and output register.
// Depends on tsl_pkg, tsl_rsp_if and tsl_ram.
module tsl_datapath #(
   parameter int DEPTH   = tsl_pkg::DEFAULT_DEPTH,
   parameter int ID_BITS = tsl_pkg::DEFAULT_ID_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_cmd,
   input  logic [tsl_pkg::ID_W-1:0]    req_log_id,
   input  logic [tsl_pkg::STAMP_W-1:0] req_first_stamp,
   input  logic [tsl_pkg::STAMP_W-1:0] req_end_stamp,
   input  logic [tsl_pkg::GRAN_W-1:0]  req_granularity,
   input  tsl_pkg::cmd_type            cmd,
   output tsl_pkg::sts_type            sts,
   tsl_rsp_if.source                   rsp_if
);
   import tsl_pkg::*;

   // ids wider than the port carry no more bits than the port gives
   localparam int KEEP_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = STAMP_W + KEEP_W;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [STAMP_W-1:0] lo_ff, lo_in;
   logic [STAMP_W-1:0] hi_ff, hi_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in;
   logic               out_valid_ff, out_valid_in;
   logic [ID_W-1:0]    out_id_ff, out_id_in;
   logic               out_empty_ff, out_empty_in;
   logic               out_last_ff, out_last_in;
   logic               out_ovf_ff, out_ovf_in;

   logic               full;
   logic               wr_en;
   logic [WORD_W-1:0]  rd_word;
   logic [STAMP_W-1:0] rd_stamp;
   logic [ID_W-1:0]    rd_id;
   logic               match;
   logic               out_free;
   logic               push_held;

   // entry store: stamp above, id below
   tsl_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req_first_stamp, req_log_id[KEEP_W-1:0]}),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_word)
   );

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign wr_en    = cmd.accept_put && !full;
   assign rd_stamp = rd_word[WORD_W-1 -: STAMP_W];
   assign rd_id    = ID_W'(rd_word[KEEP_W-1:0]);
   assign match    = (rd_stamp >= lo_ff) && (rd_stamp <= hi_ff);
   assign out_free = !out_valid_ff || rsp_if.ready;

   // held match goes out, not last, when a newer match replaces it
   assign push_held = cmd.step && match && pend_valid_ff;

   // status
   always_comb begin
      sts.is_get     = (req_cmd == CMD_GET);
      sts.count_zero = (count_ff == '0);
      sts.match      = match;
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
      sts.scan_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   end

   // store fill and sticky overflow
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.accept_put) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // bounds and scan index
   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      idx_in = idx_ff;
      if (cmd.accept_get) begin
         lo_in  = widen_stamp(req_first_stamp, req_granularity, 1'b0);
         hi_in  = widen_stamp(req_end_stamp, req_granularity, 1'b1);
         idx_in = '0;
      end else if (cmd.step) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // held match
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      if (cmd.accept_get || cmd.flush) begin
         pend_valid_in = 1'b0;
      end else if (cmd.step && match) begin
         pend_valid_in = 1'b1;
         pend_id_in    = rd_id;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_id_in    = out_id_ff;
      out_empty_in = out_empty_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (push_held) begin
         out_valid_in = 1'b1;
         out_id_in    = pend_id_ff;
         out_empty_in = 1'b0;
         out_last_in  = 1'b0;
         out_ovf_in   = ovf_ff;
      end else if (cmd.flush) begin
         out_valid_in = 1'b1;
         out_id_in    = pend_valid_ff ? pend_id_ff : '0;
         out_empty_in = !pend_valid_ff;
         out_last_in  = 1'b1;
         out_ovf_in   = ovf_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      pend_id_ff   <= pend_id_in;
      out_id_ff    <= out_id_in;
      out_empty_ff <= out_empty_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.match_id   = out_id_ff;
   assign rsp_if.empty_res  = out_empty_ff;
   assign rsp_if.last       = out_last_ff;
   assign rsp_if.overflowed = out_ovf_ff;
endmodule

>>> rtl/timestamp_range_log_store.sv
// Timestamp range log store: a put is taken in the idle state, and puts can follow every cycle
// while no retrieve is in progress. A retrieve is accepted, then each stored entry is read and
// compared in turn on the single read port, then the final result is flushed; an empty store goes
// straight from accept to flush. Result stalls hold the compare and flush steps. A match is output
// the cycle after the next match is compared, or after the flush; one item is worked on at a time.
// Reset is synchronous, active high: clears fill count, overflow flag, sequencer and output valid.
module timestamp_range_log_store #(
   parameter int DEPTH   = tsl_pkg::DEFAULT_DEPTH,
   parameter int ID_BITS = tsl_pkg::DEFAULT_ID_BITS
) (
   input  logic      clock,
   input  logic      reset,
   tsl_req_if.sink   req_if,
   tsl_rsp_if.source rsp_if
);
   import tsl_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   assign req_if.ready = req_ready;

   // sequencer
   tsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // store and scan datapath
   tsl_datapath #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_if.cmd),
      .req_log_id      (req_if.log_id),
      .req_first_stamp (req_if.first_stamp),
      .req_end_stamp   (req_if.end_stamp),
      .req_granularity (req_if.granularity),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_if          (rsp_if)
   );

`ifndef SYNTHESIS
   // an empty result always closes its retrieve
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.empty_res |-> rsp_if.last)
      else $error("empty result without last");

   // no item is taken while the store is being scanned
   a_busy_during_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !req_ready)
      else $error("request taken during scan");

   // every read is followed by its compare cycle
   a_read_then_compare: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> !cmd.rd_en)
      else $error("back-to-back reads");

   // a result is only loaded into a free output register
   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && sts.match && sts.pend_valid) || cmd.flush |-> sts.out_free)
      else $error("output overwritten");
`endif
endmodule
